// File: hdl/crlb_pkg.sv
// ----------------------------------------------------------------------------
// crlb_pkg: shared types and constants for the CR LF line ring buffer
// Character codes, result status codes, controller states and the command
// and status groups that pass between controller and datapath.
// ----------------------------------------------------------------------------
package crlb_pkg;

    localparam int RING_DEPTH_DEF = 512;
    localparam int OUT_CNT_W      = 10;

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_NUL = 8'h00;

    typedef enum logic [2:0] {
        STAT_STORED  = 3'd0,
        STAT_FULL    = 3'd1,
        STAT_ZERO    = 3'd2,
        STAT_CONTENT = 3'd3,
        STAT_EOL     = 3'd4,
        STAT_NOLINE  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_POP_EVAL
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load_req;
        logic push_exec;
        logic pop_read;
        logic pop_eval;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic req_is_pop;
    } dp_stat_t;

endpackage

// File: hdl/crlf_line_ring_buffer.sv
// ----------------------------------------------------------------------------
// crlf_line_ring_buffer: byte ring that frames CR LF terminated lines
// Pushes store received non-zero bytes while there is room; pops return content
// of the oldest complete line or report its end, consuming the CR LF pair, or report that no line is ready.
// ----------------------------------------------------------------------------
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+------------------------------------------
//  request  | start, busy          | req_type, data_byte
//  result   | done (one-cycle)     | status, out_byte, lines_ready, bytes_held
//
// Sequence: a push beat is executed, then its result is registered; a pop beat
// first reads the two head bytes from the ring's registered read ports, then
// evaluates them and registers the result.
// A new request may be accepted in the same cycle as the done strobe.
// Reset: asynchronous, active low; indices and counters clear at once, the
// ring contents are not cleared and need no sweep.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module crlf_line_ring_buffer #(
    parameter int RING_DEPTH = crlb_pkg::RING_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic       req_type,
    input  logic [7:0] data_byte,
    output logic       done,
    output logic [2:0] status,
    output logic [7:0] out_byte,
    output logic [9:0] lines_ready,
    output logic [9:0] bytes_held
);
    import crlb_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  dp_stat;

    // sequencer: decides which step the datapath runs each cycle
    crlb_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .dp_stat (dp_stat),
        .busy    (busy),
        .cmd     (cmd)
    );

    // ring, indices, counters and the result register
    crlb_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .req_type    (req_type),
        .data_byte   (data_byte),
        .dp_stat     (dp_stat),
        .done        (done),
        .status      (status),
        .out_byte    (out_byte),
        .lines_ready (lines_ready),
        .bytes_held  (bytes_held)
    );

    // a result is only ever presented once the sequencer is back to idle
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");

    // an accepted beat always occupies the sequencer next cycle
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("accepted beat did not start");

    // held byte count moves only at a result
    assert property (@(posedge clk) disable iff (!rst_n) !done |-> $stable(bytes_held))
        else $error("byte count changed without a result");

    // an end of line consumes exactly one complete line
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STAT_EOL) |-> lines_ready == 10'($past(lines_ready) - 10'd1))
        else $error("end of line did not consume one line");

endmodule

// File: hdl/crlb_ctrl.sv
// ----------------------------------------------------------------------------
// crlb_ctrl: request sequencer
// Takes a request, runs a push in one step or a pop as read then evaluate.
// ----------------------------------------------------------------------------
module crlb_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  crlb_pkg::dp_stat_t   dp_stat,
    output logic                 busy,
    output crlb_pkg::ctrl_cmd_t  cmd
);
    import crlb_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = dp_stat.req_is_pop ? S_POP_EVAL : S_IDLE;
            end
            S_POP_EVAL:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                busy         = 1'b0;
                cmd.load_req = start;
            end
            S_EXEC:
            begin
                cmd.push_exec = !dp_stat.req_is_pop;
                cmd.pop_read  = dp_stat.req_is_pop;
            end
            S_POP_EVAL:
            begin
                cmd.pop_eval = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

// File: hdl/crlb_dp.sv
// ----------------------------------------------------------------------------
// crlb_dp: ring storage, indices, counters and result registers
// One write port and two registered read ports on the byte ring.
// ----------------------------------------------------------------------------
module crlb_dp #(
    parameter int RING_DEPTH = crlb_pkg::RING_DEPTH_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  crlb_pkg::ctrl_cmd_t  cmd,
    input  logic                 req_type,
    input  logic [7:0]           data_byte,
    output crlb_pkg::dp_stat_t   dp_stat,
    output logic                 done,
    output logic [2:0]           status,
    output logic [7:0]           out_byte,
    output logic [9:0]           lines_ready,
    output logic [9:0]           bytes_held
);
    import crlb_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam int CW = $clog2(RING_DEPTH + 1);
    localparam int EW = (CW > OUT_CNT_W) ? CW : OUT_CNT_W;

    function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p);
        next_pos = (p == AW'(RING_DEPTH - 1)) ? '0 : p + AW'(1);
    endfunction

    logic [7:0]    ring_mem [RING_DEPTH];

    logic          req_type_reg;
    logic [7:0]    data_reg;
    logic [7:0]    rd0_reg;
    logic [7:0]    rd1_reg;

    logic [AW-1:0] wr_idx_reg, wr_idx_next;
    logic [AW-1:0] rd_idx_reg, rd_idx_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic [CW-1:0] lines_reg, lines_next;
    logic          last_cr_reg, last_cr_next;
    logic          done_reg, done_next;
    status_t       status_reg, status_next;
    logic [7:0]    out_byte_reg, out_byte_next;

    logic [AW-1:0] rd_plus1;
    logic [AW-1:0] rd_plus2;
    logic          mem_we;
    logic [EW-1:0] fill_ext;
    logic [EW-1:0] lines_ext;

    assign rd_plus1 = next_pos(rd_idx_reg);
    assign rd_plus2 = next_pos(rd_plus1);

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_type_reg <= req_type;
            data_reg     <= data_byte;
        end
    end

    // ring storage: write on a stored push, read both head bytes for a pop
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ring_mem[wr_idx_reg] <= data_reg;
        end
        if (cmd.pop_read)
        begin
            rd0_reg <= ring_mem[rd_idx_reg];
            rd1_reg <= ring_mem[rd_plus1];
        end
    end

    always_comb
    begin
        wr_idx_next   = wr_idx_reg;
        rd_idx_next   = rd_idx_reg;
        fill_next     = fill_reg;
        lines_next    = lines_reg;
        last_cr_next  = last_cr_reg;
        status_next   = status_reg;
        out_byte_next = out_byte_reg;
        done_next     = 1'b0;
        mem_we        = 1'b0;
        if (cmd.push_exec)
        begin
            done_next     = 1'b1;
            out_byte_next = CH_NUL;
            priority if (data_reg == CH_NUL)
            begin
                status_next = STAT_ZERO;
            end
            else if (fill_reg >= CW'(RING_DEPTH))
            begin
                status_next = STAT_FULL;
            end
            else
            begin
                mem_we       = 1'b1;
                wr_idx_next  = next_pos(wr_idx_reg);
                fill_next    = fill_reg + CW'(1);
                if (data_reg == CH_LF && last_cr_reg)
                begin
                    lines_next = lines_reg + CW'(1);
                end
                last_cr_next = (data_reg == CH_CR);
                status_next  = STAT_STORED;
            end
        end
        else if (cmd.pop_eval)
        begin
            done_next     = 1'b1;
            out_byte_next = CH_NUL;
            priority if (lines_reg == '0 || fill_reg == '0)
            begin
                status_next = STAT_NOLINE;
            end
            else if (rd0_reg == CH_CR && fill_reg >= CW'(2) && rd1_reg == CH_LF)
            begin
                rd_idx_next = rd_plus2;
                fill_next   = fill_reg - CW'(2);
                lines_next  = lines_reg - CW'(1);
                status_next = STAT_EOL;
            end
            else
            begin
                out_byte_next = rd0_reg;
                rd_idx_next   = rd_plus1;
                fill_next     = fill_reg - CW'(1);
                status_next   = STAT_CONTENT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg  <= '0;
            rd_idx_reg  <= '0;
            fill_reg    <= '0;
            lines_reg   <= '0;
            last_cr_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else
        begin
            wr_idx_reg  <= wr_idx_next;
            rd_idx_reg  <= rd_idx_next;
            fill_reg    <= fill_next;
            lines_reg   <= lines_next;
            last_cr_reg <= last_cr_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg   <= status_next;
        out_byte_reg <= out_byte_next;
    end

    assign fill_ext  = EW'(fill_reg);
    assign lines_ext = EW'(lines_reg);

    assign dp_stat.req_is_pop = req_type_reg;
    assign done        = done_reg;
    assign status      = status_reg;
    assign out_byte    = out_byte_reg;
    assign lines_ready = lines_ext[OUT_CNT_W-1:0];
    assign bytes_held  = fill_ext[OUT_CNT_W-1:0];

endmodule

// File: sim/tb_crlf_line_ring_buffer.sv
// ----------------------------------------------------------------------------
// tb_crlf_line_ring_buffer: self-checking bench for the CR LF line ring buffer
// A directed table walks reset, empty and lone-CR cases, then random traffic
// built mostly from whole lines fills and drains the ring. At the end the
// ring is locked full with no complete line, which also carries the write
// index round the ring. Every result is checked against its directed row's
// own expectation where the row gives one, else against a local shadow of the ring.
// ----------------------------------------------------------------------------
module tb_crlf_line_ring_buffer;

    import crlb_pkg::*;

    localparam int DEPTH       = RING_DEPTH_DEF;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int MAIN_BEATS  = 360;      // directed plus random line traffic
    localparam int TAIL_CYCLES = 8;        // idle slack after the bench has drained
    localparam int CYCLE_LIMIT = 200000;   // watchdog bound, ample for ~1000 beats

    // request codes on req_type
    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_POP  = 1'b1;

    // one result beat as the block reports it
    typedef struct packed {
        status_t           status;
        logic [7:0]        byte_val;
        logic [OUT_CNT_W-1:0] lines;
        logic [OUT_CNT_W-1:0] held;
    } line_result_t;

    // one row of the directed table; typed rows carry their own expectation
    typedef struct packed {
        logic         rq;
        logic [7:0]   db;
        logic         typed;
        line_result_t res;
    } stim_row_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    logic       req_type;
    logic [7:0] data_byte;
    logic       done;
    logic [2:0] status;
    logic [7:0] out_byte;
    logic [9:0] lines_ready;
    logic [9:0] bytes_held;

    // shadow of the block state, advanced once per accepted beat
    logic [7:0]       shadow_ring [DEPTH];
    logic [IDX_W-1:0] shadow_wr;
    logic [IDX_W-1:0] shadow_rd;
    int               shadow_fill;
    int               shadow_lines;
    logic             shadow_cr_last;

    line_result_t pending_results [$];

    int beats_sent;
    int results_seen;
    int faults;
    int cycle_count;
    int burst_left;
    int peak_fill;
    int status_seen [8];

    stim_row_t directed_rows [24];

    crlf_line_ring_buffer #(
        .RING_DEPTH (DEPTH)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .req_type    (req_type),
        .data_byte   (data_byte),
        .done        (done),
        .status      (status),
        .out_byte    (out_byte),
        .lines_ready (lines_ready),
        .bytes_held  (bytes_held)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Advance the shadow ring by one beat and return the result it implies.
    function automatic line_result_t frame_step(input logic rq, input logic [7:0] db);
        line_result_t     res;
        logic [IDX_W-1:0] after_head;
        logic [7:0]       head;
        res.status   = STAT_STORED;
        res.byte_val = 8'h00;
        if (rq == REQ_PUSH)
        begin
            if (db == CH_NUL)
                res.status = STAT_ZERO;
            else if (shadow_fill >= DEPTH)
                res.status = STAT_FULL;       // drop, CR memory untouched
            else
            begin
                shadow_ring[shadow_wr] = db;
                shadow_wr = (shadow_wr == IDX_W'(DEPTH - 1)) ? '0 : shadow_wr + 1'b1;
                shadow_fill++;
                if (db == CH_LF && shadow_cr_last)
                    shadow_lines++;
                shadow_cr_last = (db == CH_CR);
            end
        end
        else
        begin
            if (shadow_lines == 0 || shadow_fill == 0)
                res.status = STAT_NOLINE;
            else
            begin
                after_head = (shadow_rd == IDX_W'(DEPTH - 1)) ? '0 : shadow_rd + 1'b1;
                head       = shadow_ring[shadow_rd];
                if (head == CH_CR && shadow_fill >= 2 && shadow_ring[after_head] == CH_LF)
                begin
                    // consume the CR LF pair and close the line
                    shadow_rd = (after_head == IDX_W'(DEPTH - 1)) ? '0 : after_head + 1'b1;
                    shadow_fill -= 2;
                    shadow_lines--;
                    res.status = STAT_EOL;
                end
                else
                begin
                    // a lone CR lands here too, as ordinary content
                    res.byte_val = head;
                    shadow_rd    = after_head;
                    shadow_fill--;
                    res.status   = STAT_CONTENT;
                end
            end
        end
        res.lines = OUT_CNT_W'(shadow_lines);
        res.held  = OUT_CNT_W'(shadow_fill);
        return res;
    endfunction

    function automatic stim_row_t row(input logic rq, input logic [7:0] db, input logic typed,
                                      input status_t st, input logic [7:0] ob,
                                      input int ln, input int hd);
        stim_row_t r;
        r.rq           = rq;
        r.db           = db;
        r.typed        = typed;
        r.res.status   = st;
        r.res.byte_val = ob;
        r.res.lines    = OUT_CNT_W'(ln);
        r.res.held     = OUT_CNT_W'(hd);
        return r;
    endfunction

    // line text: mostly any non-zero byte, now and then a CR
    function automatic logic [7:0] text_byte();
        return ($urandom_range(0, 11) == 0) ? CH_CR : 8'($urandom_range(1, 255));
    endfunction

    // any non-zero byte that can neither open nor close a line
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(1, 253));
        if (b >= CH_LF)
            b = b + 8'd1;
        if (b >= CH_CR)
            b = b + 8'd1;
        return b;
    endfunction

    // Present one beat, hold it until accepted, record its expectation, then
    // idle: stay in the current burst or drop start for a random gap.
    // Called and returns on a falling edge.
    task automatic send_beat(input logic rq, input logic [7:0] db,
                             input logic typed = 1'b0, input line_result_t typed_res = '0);
        line_result_t predicted;
        int           idle_gap;
        start     <= 1'b1;
        req_type  <= rq;
        data_byte <= db;
        do
            @(posedge clk);
        while (busy);
        predicted = frame_step(rq, db);
        pending_results.push_back(typed ? typed_res : predicted);
        beats_sent++;
        @(negedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            idle_gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 20)
                                                   : $urandom_range(0, 3);
            if (idle_gap != 0)
            begin
                start <= 1'b0;
                repeat (idle_gap) @(negedge clk);
            end
            // long bursts give stretches with no idling at all
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // Hold the request side quiet until every expected result has come back.
    task automatic hold_until_drained();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Result side: every done strobe is one beat, checked against the oldest
    // expectation.
    always @(posedge clk)
    begin
        line_result_t got;
        line_result_t want;
        if (rst_n && done)
        begin
            got.status   = status_t'(status);
            got.byte_val = out_byte;
            got.lines    = lines_ready;
            got.held     = bytes_held;
            results_seen++;
            status_seen[status]++;
            if (bytes_held > peak_fill)
                peak_fill = bytes_held;
            if (pending_results.size() == 0)
            begin
                faults++;
                if (faults <= 10)
                    $display({"result %0d with none pending: ",
                              "status %0d byte %02h lines %0d held %0d"},
                             results_seen, status, out_byte, lines_ready, bytes_held);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got !== want)
                begin
                    faults++;
                    if (faults <= 10)
                        $display({"result %0d mismatch: expected status %0d byte %02h lines %0d ",
                                  "held %0d, got status %0d byte %02h lines %0d held %0d"},
                                 results_seen, want.status, want.byte_val, want.lines,
                                 want.held, status, out_byte, lines_ready, bytes_held);
                end
            end
        end
    end

    always @(posedge clk)
        cycle_count++;

    // watchdog: stop a hung run
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("tb_crlf_line_ring_buffer: errors");
        $finish;
    end

    initial
    begin
        int ep;
        int len;
        int k;

        rst_n          = 1'b0;
        start          = 1'b0;
        req_type       = REQ_PUSH;
        data_byte      = 8'h00;
        shadow_wr      = '0;
        shadow_rd      = '0;
        shadow_fill    = 0;
        shadow_lines   = 0;
        shadow_cr_last = 1'b0;
        beats_sent     = 0;
        results_seen   = 0;
        faults         = 0;
        cycle_count    = 0;
        burst_left     = 0;
        peak_fill      = 0;
        foreach (status_seen[i])
            status_seen[i] = 0;

        // Directed table: empty ring, zero skip, lone CR as content, LF with no
        // CR in front, a zero between CR and LF, and both byte extremes.
        directed_rows = '{
            row(REQ_POP,  8'h00, 1'b1, STAT_NOLINE,  8'h00, 0, 0),
            row(REQ_PUSH, CH_NUL, 1'b1, STAT_ZERO,   8'h00, 0, 0),
            row(REQ_PUSH, 8'hFF, 1'b1, STAT_STORED,  8'h00, 0, 1),
            row(REQ_PUSH, 8'h01, 1'b1, STAT_STORED,  8'h00, 0, 2),
            row(REQ_PUSH, CH_CR, 1'b1, STAT_STORED,  8'h00, 0, 3),
            row(REQ_PUSH, 8'h41, 1'b0, STAT_STORED,  8'h00, 0, 0),
            row(REQ_POP,  8'hFF, 1'b1, STAT_NOLINE,  8'h00, 0, 4),
            row(REQ_PUSH, CH_CR, 1'b0, STAT_STORED,  8'h00, 0, 0),
            row(REQ_PUSH, CH_LF, 1'b1, STAT_STORED,  8'h00, 1, 6),
            row(REQ_PUSH, CH_LF, 1'b0, STAT_STORED,  8'h00, 0, 0),
            row(REQ_POP,  8'h00, 1'b1, STAT_CONTENT, 8'hFF, 1, 6),
            row(REQ_POP,  8'h00, 1'b0, STAT_STORED,  8'h00, 0, 0),
            row(REQ_POP,  8'h00, 1'b0, STAT_STORED,  8'h00, 0, 0),
            row(REQ_POP,  8'h00, 1'b0, STAT_STORED,  8'h00, 0, 0),
            row(REQ_POP,  8'h00, 1'b1, STAT_EOL,     8'h00, 0, 1),
            row(REQ_POP,  8'h00, 1'b1, STAT_NOLINE,  8'h00, 0, 1),
            row(REQ_PUSH, CH_CR, 1'b0, STAT_STORED,  8'h00, 0, 0),
            row(REQ_PUSH, CH_NUL, 1'b1, STAT_ZERO,   8'h00, 0, 2),
            row(REQ_PUSH, CH_LF, 1'b0, STAT_STORED,  8'h00, 0, 0),
            row(REQ_POP,  8'h00, 1'b0, STAT_STORED,  8'h00, 0, 0),
            row(REQ_POP,  8'h00, 1'b1, STAT_EOL,     8'h00, 0, 0),
            row(REQ_POP,  8'h00, 1'b1, STAT_NOLINE,  8'h00, 0, 0),
            row(REQ_PUSH, 8'h80, 1'b0, STAT_STORED,  8'h00, 0, 0),
            row(REQ_PUSH, 8'h7F, 1'b0, STAT_STORED,  8'h00, 0, 0)
        };

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
            send_beat(directed_rows[i].rq, directed_rows[i].db,
                      directed_rows[i].typed, directed_rows[i].res);

        // pause the sender until the block has answered everything
        hold_until_drained();

        while (beats_sent < MAIN_BEATS)
        begin
            ep = $urandom_range(0, 19);
            // drain a crowded ring while there is a line to take
            if (shadow_fill > 350)
                ep = (shadow_lines != 0) ? 9 : 0;
            if (ep < 9)
            begin
                // one well-formed line with random text
                len = $urandom_range(0, 10);
                repeat (len) send_beat(REQ_PUSH, text_byte());
                send_beat(REQ_PUSH, CH_CR);
                send_beat(REQ_PUSH, CH_LF);
            end
            else if (ep < 16)
                repeat ($urandom_range(1, 16)) send_beat(REQ_POP, 8'($urandom_range(0, 255)));
            else if (ep < 18)
            begin
                // noise: any request, zero bytes included
                repeat ($urandom_range(1, 6))
                begin
                    k = $urandom_range(0, 3);
                    send_beat(1'($urandom_range(0, 1)),
                              (k == 0) ? CH_NUL : 8'($urandom_range(0, 255)));
                end
            end
            else
            begin
                // broken framing
                case ($urandom_range(0, 3))
                    0:
                    begin
                        send_beat(REQ_PUSH, CH_CR);
                        send_beat(REQ_PUSH, plain_byte());
                    end
                    1:
                        send_beat(REQ_PUSH, CH_LF);
                    2:
                    begin
                        send_beat(REQ_PUSH, CH_CR);
                        send_beat(REQ_PUSH, CH_NUL);
                        send_beat(REQ_PUSH, CH_LF);
                    end
                    default:
                    begin
                        send_beat(REQ_PUSH, CH_CR);
                        send_beat(REQ_PUSH, CH_CR);
                        send_beat(REQ_PUSH, CH_LF);
                    end
                endcase
            end
        end

        hold_until_drained();

        // Lock-up: take every line, then fill with bytes that can never close
        // one. Pushes bounce, pops find no line, a zero is still only skipped.
        while (shadow_lines != 0)
            send_beat(REQ_POP, 8'($urandom_range(0, 255)));
        repeat (DEPTH - shadow_fill + 6) send_beat(REQ_PUSH, plain_byte());
        send_beat(REQ_PUSH, CH_NUL);
        send_beat(REQ_PUSH, CH_CR);
        repeat (6) send_beat(REQ_POP, 8'($urandom_range(0, 255)));

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        faults += pending_results.size();

        $display({"%0d beats: %0d stored, %0d dropped on full, %0d zero skipped, ",
                  "%0d content, %0d end of line, %0d no line"},
                 results_seen, status_seen[STAT_STORED], status_seen[STAT_FULL],
                 status_seen[STAT_ZERO], status_seen[STAT_CONTENT], status_seen[STAT_EOL],
                 status_seen[STAT_NOLINE]);
        $display("peak fill %0d of %0d bytes, %0d faults in %0d cycles",
                 peak_fill, DEPTH, faults, cycle_count);
        if (faults == 0)
            $display("tb_crlf_line_ring_buffer: clean");
        else
            $display("tb_crlf_line_ring_buffer: errors");
        $finish;
    end

endmodule

// File: crlf_line_ring_buffer.f
hdl/crlb_pkg.sv
hdl/crlb_ctrl.sv
hdl/crlb_dp.sv
hdl/crlf_line_ring_buffer.sv
sim/tb_crlf_line_ring_buffer.sv
